>>> sv/multi_pattern_string_matcher_macros.svh
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_STRING_MATCHER_MACROS_SVH
`define MULTI_PATTERN_STRING_MATCHER_MACROS_SVH

// same-cycle implication
`define MPSM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MPSM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg
// field widths, default sizes and item/result codes of the string matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpsm_pkg;

	// default sizes
	localparam int MAX_NODES_DEF       = 1024;
	localparam int MAX_PATTERNS_DEF    = 1024;
	localparam int MAX_PATTERN_LEN_DEF = 32;
	localparam int RESULT_CAP          = 32;

	// field widths
	localparam int MODE_W = 2;
	localparam int SYM_W  = 8;
	localparam int ID_W   = 10;
	localparam int KIND_W = 3;
	localparam int POS_W  = 32;

	// item modes
	localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BUILD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_MATCH  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STORED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LONG   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BUILT  = 3'd4;

endpackage

>>> sv/multi_pattern_string_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher
// aho-corasick matcher: trie insert, breadth-first link build, text scan
// ----------------------------------------------------------------------------
// pattern byte: child read, then trie update; on the last byte also id reduction and result
// build: init, then per node a pop and parent-link read, per symbol a child read and per failure-link hop a goto read
// text byte: a read and check per goto/fail probe and per chain node
// one item at a time; the child table read sets the pace
// after reset a clearing pass over the child table runs; input stalls
// a finished result waits in the output register while the next item enters
`timescale 1ns / 1ps

`include "multi_pattern_string_matcher_macros.svh"

module multi_pattern_string_matcher
	import mpsm_pkg::*;
#(
	parameter int MAX_NODES       = MAX_NODES_DEF,
	parameter int MAX_PATTERNS    = MAX_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [SYM_W-1:0]  symbol,
	input  logic              last_of_pattern,
	input  logic [ID_W-1:0]   pattern_id,
	input  logic              start_of_text,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   match_pattern,
	output logic [POS_W-1:0]  end_position,
	output logic              last
);

	localparam int NW          = $clog2(MAX_NODES);
	localparam int CNTW        = $clog2(MAX_NODES + 1);
	localparam int CAW         = NW + SYM_W;
	localparam int CHILD_DEPTH = MAX_NODES * 256;
	localparam int DW          = $clog2(MAX_PATTERN_LEN + 1);
	localparam int NCW         = $clog2(RESULT_CAP + 1);
	localparam int RSH         = 20;
	localparam int RW          = RSH + 1;
	localparam int MPW         = $clog2(MAX_PATTERNS + 1);
	localparam int MW          = ID_W + MPW;
	localparam int IW          = 1 + ID_W;
	localparam logic [RW-1:0]  RECIP_C = RW'((1 << RSH) / MAX_PATTERNS);

	// sequencer states
	localparam logic [4:0] S_CLR    = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_P_RD   = 5'd2;
	localparam logic [4:0] S_P_UPD  = 5'd3;
	localparam logic [4:0] S_P_Q    = 5'd4;
	localparam logic [4:0] S_P_R    = 5'd5;
	localparam logic [4:0] S_P_FIN  = 5'd6;
	localparam logic [4:0] S_B_INIT = 5'd7;
	localparam logic [4:0] S_B_POP  = 5'd8;
	localparam logic [4:0] S_B_PAR  = 5'd9;
	localparam logic [4:0] S_B_PF   = 5'd10;
	localparam logic [4:0] S_B_PFC  = 5'd11;
	localparam logic [4:0] S_B_CRD  = 5'd12;
	localparam logic [4:0] S_B_CCHK = 5'd13;
	localparam logic [4:0] S_B_GRD  = 5'd14;
	localparam logic [4:0] S_B_GCHK = 5'd15;
	localparam logic [4:0] S_B_DONE = 5'd16;
	localparam logic [4:0] S_T_RD   = 5'd17;
	localparam logic [4:0] S_T_CHK  = 5'd18;
	localparam logic [4:0] S_T_QRD  = 5'd19;
	localparam logic [4:0] S_T_QD   = 5'd20;
	localparam logic [4:0] S_T_END  = 5'd21;

	logic [4:0]       state_q;

	// item and walk registers
	logic [SYM_W-1:0] sym_q;
	logic             lastp_q;
	logic [ID_W-1:0]  id_q;
	logic [ID_W-1:0]  quot_q;
	logic [ID_W-1:0]  stored_id_q;
	logic [CNTW-1:0]  node_count_q;
	logic [NW-1:0]    ins_node_q;
	logic [DW-1:0]    ins_depth_q;
	logic             ins_failed_q;
	logic [NW-1:0]    search_node_q;
	logic [POS_W-1:0] text_pos_q;
	logic [NW-1:0]    node_a_q;
	logic [SYM_W-1:0] sym_a_q;
	logic [NW-1:0]    f_q;
	logic [NW-1:0]    parent_q;
	logic [NW-1:0]    pfail_q;
	logic [NW-1:0]    child_q;
	logic [CNTW-1:0]  head_q;
	logic [CNTW-1:0]  tail_q;
	logic [CAW-1:0]   clr_q;
	logic             pend_v_q;
	logic [ID_W-1:0]  pend_pat_q;
	logic [NCW-1:0]   nres_q;

	// memory ports
	logic [NW-1:0]    child_rd_q;
	logic             child_we;
	logic [CAW-1:0]   child_wa;
	logic [NW-1:0]    child_wd;
	logic [NW-1:0]    fail_rd_q;
	logic             fail_we;
	logic [NW-1:0]    fail_wa;
	logic [NW-1:0]    fail_wd;
	logic [IW-1:0]    info_rd_q;
	logic             info_we;
	logic [NW-1:0]    info_wa;
	logic [IW-1:0]    info_wd;
	logic [NW-1:0]    queue_rd_q;
	logic             queue_we;
	logic [NW-1:0]    queue_wa;
	logic [NW-1:0]    queue_wd;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [ID_W-1:0]   pat_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic              out_free;
	logic              push;
	logic [KIND_W-1:0] push_kind;
	logic [ID_W-1:0]   push_pat;
	logic [POS_W-1:0]  push_pos;
	logic              push_last;

	// helper terms
	logic                  accept;
	logic                  clr_node;
	logic                  p_new;
	logic                  b_link_we;
	logic [NW-1:0]         b_link_node;
	logic [NW-1:0]         b_link_val;
	logic                  b_q_push;
	logic                  b_next_c;
	logic                  t_hit;
	logic [ID_W+RW-1:0]    quot_prod;
	logic [MW-1:0]         rem_raw;
	logic [MW-1:0]         rem_fix;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign clr_node = (clr_q < CAW'(MAX_NODES));
	assign p_new    = (child_rd_q == '0) && (node_count_q < CNTW'(MAX_NODES));

	// id reduction by reciprocal, then one correction step
	assign quot_prod = (ID_W+RW)'(id_q) * (ID_W+RW)'(RECIP_C);
	assign rem_raw   = MW'(id_q) - MW'(quot_q) * MW'(MAX_PATTERNS);
	assign rem_fix   = (rem_raw >= MW'(MAX_PATTERNS)) ? rem_raw - MW'(MAX_PATTERNS) : rem_raw;

	// build: failure link decided this cycle
	always_comb begin
		b_link_we   = 1'b0;
		b_link_node = child_q;
		b_link_val  = '0;
		b_next_c    = 1'b0;
		case (state_q)
			S_B_CCHK: begin
				if (child_rd_q == '0) begin
					b_next_c = 1'b1;
				end else if (parent_q == '0) begin
					b_link_we   = 1'b1;
					b_link_node = child_rd_q;
					b_next_c    = 1'b1;
				end
			end
			S_B_GCHK: begin
				if (child_rd_q != '0) begin
					b_link_we  = 1'b1;
					b_link_val = child_rd_q;
					b_next_c   = 1'b1;
				end else if (f_q == '0) begin
					b_link_we = 1'b1;
					b_next_c  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end
	assign b_q_push = b_link_we && (tail_q < CNTW'(MAX_NODES));

	assign t_hit = info_rd_q[IW-1] && (nres_q < NCW'(RESULT_CAP));

	// memory write selection
	always_comb begin
		child_we = 1'b0;
		child_wa = clr_q;
		child_wd = '0;
		fail_we  = 1'b0;
		fail_wa  = clr_q[NW-1:0];
		fail_wd  = '0;
		info_we  = 1'b0;
		info_wa  = clr_q[NW-1:0];
		info_wd  = '0;
		queue_we = 1'b0;
		queue_wa = tail_q[NW-1:0];
		queue_wd = b_link_node;
		case (state_q)
			S_CLR: begin
				child_we = 1'b1;
				fail_we  = clr_node;
				info_we  = clr_node;
			end
			S_P_UPD: begin
				child_we = p_new;
				child_wa = {ins_node_q, sym_q};
				child_wd = node_count_q[NW-1:0];
			end
			S_P_FIN: begin
				info_we = out_free && !ins_failed_q;
				info_wa = ins_node_q;
				info_wd = {1'b1, stored_id_q};
			end
			S_B_INIT: begin
				queue_we = 1'b1;
				queue_wa = '0;
				queue_wd = '0;
			end
			S_B_CCHK, S_B_GCHK: begin
				fail_we  = b_link_we;
				fail_wa  = b_link_node;
				fail_wd  = b_link_val;
				queue_we = b_q_push;
			end
			default: begin
			end
		endcase
	end

	// result push selection
	always_comb begin
		push      = 1'b0;
		push_kind = KIND_MATCH;
		push_pat  = pend_pat_q;
		push_pos  = text_pos_q;
		push_last = 1'b0;
		case (state_q)
			S_P_FIN: begin
				push      = out_free;
				push_pat  = stored_id_q;
				push_pos  = '0;
				push_last = 1'b1;
				if (!ins_failed_q) begin
					push_kind = KIND_STORED;
				end else if (ins_depth_q >= DW'(MAX_PATTERN_LEN)) begin
					push_kind = KIND_LONG;
				end else begin
					push_kind = KIND_FULL;
				end
			end
			S_B_DONE: begin
				push      = out_free;
				push_kind = KIND_BUILT;
				push_pat  = '0;
				push_pos  = '0;
				push_last = 1'b1;
			end
			S_T_QD: begin
				push = t_hit && pend_v_q && out_free;
			end
			S_T_END: begin
				push      = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// child table
	logic [NW-1:0] child_mem [CHILD_DEPTH];
	always_ff @(posedge clk) begin
		if (child_we) child_mem[child_wa] <= child_wd;
		child_rd_q <= child_mem[{node_a_q, sym_a_q}];
	end

	// failure links
	logic [NW-1:0] fail_mem [MAX_NODES];
	always_ff @(posedge clk) begin
		if (fail_we) fail_mem[fail_wa] <= fail_wd;
		fail_rd_q <= fail_mem[f_q];
	end

	// terminal flag and pattern id per node
	logic [IW-1:0] info_mem [MAX_NODES];
	always_ff @(posedge clk) begin
		if (info_we) info_mem[info_wa] <= info_wd;
		info_rd_q <= info_mem[f_q];
	end

	// breadth-first queue
	logic [NW-1:0] queue_mem [MAX_NODES];
	always_ff @(posedge clk) begin
		if (queue_we) queue_mem[queue_wa] <= queue_wd;
		queue_rd_q <= queue_mem[head_q[NW-1:0]];
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q <= push_kind;
			pat_q  <= push_pat;
			pos_q  <= push_pos;
			last_q <= push_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign match_pattern = pat_q;
	assign end_position  = pos_q;
	assign last          = last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			sym_q         <= '0;
			lastp_q       <= 1'b0;
			id_q          <= '0;
			quot_q        <= '0;
			stored_id_q   <= '0;
			node_count_q  <= CNTW'(1);
			ins_node_q    <= '0;
			ins_depth_q   <= '0;
			ins_failed_q  <= 1'b0;
			search_node_q <= '0;
			text_pos_q    <= '0;
			node_a_q      <= '0;
			sym_a_q       <= '0;
			f_q           <= '0;
			parent_q      <= '0;
			pfail_q       <= '0;
			child_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			pend_v_q      <= 1'b0;
			pend_pat_q    <= '0;
			nres_q        <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CAW'(1);
					if (clr_q == CAW'(CHILD_DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						sym_q    <= symbol;
						lastp_q  <= last_of_pattern;
						id_q     <= pattern_id;
						sym_a_q  <= symbol;
						case (mode)
							MODE_PATTERN: begin
								node_a_q <= ins_node_q;
								if (ins_failed_q) begin
									state_q <= last_of_pattern ? S_P_Q : S_IDLE;
								end else if (ins_depth_q >= DW'(MAX_PATTERN_LEN)) begin
									ins_failed_q <= 1'b1;
									state_q      <= last_of_pattern ? S_P_Q : S_IDLE;
								end else begin
									state_q <= S_P_RD;
								end
							end
							MODE_BUILD: begin
								state_q <= S_B_INIT;
							end
							MODE_TEXT: begin
								node_a_q   <= start_of_text ? '0 : search_node_q;
								f_q        <= start_of_text ? '0 : search_node_q;
								text_pos_q <= (start_of_text ? '0 : text_pos_q) + POS_W'(1);
								pend_v_q   <= 1'b0;
								nres_q     <= '0;
								state_q    <= S_T_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				// pattern insert
				S_P_RD: begin
					state_q <= S_P_UPD;
				end
				S_P_UPD: begin
					if (child_rd_q != '0) begin
						ins_node_q  <= child_rd_q;
						ins_depth_q <= ins_depth_q + DW'(1);
					end else if (p_new) begin
						ins_node_q   <= node_count_q[NW-1:0];
						node_count_q <= node_count_q + CNTW'(1);
						ins_depth_q  <= ins_depth_q + DW'(1);
					end else begin
						ins_failed_q <= 1'b1;
					end
					state_q <= lastp_q ? S_P_Q : S_IDLE;
				end
				S_P_Q: begin
					quot_q  <= quot_prod[RSH +: ID_W];
					state_q <= S_P_R;
				end
				S_P_R: begin
					stored_id_q <= rem_fix[ID_W-1:0];
					state_q     <= S_P_FIN;
				end
				S_P_FIN: begin
					if (out_free) begin
						ins_node_q   <= '0;
						ins_depth_q  <= '0;
						ins_failed_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end

				// failure link build
				S_B_INIT: begin
					head_q  <= '0;
					tail_q  <= CNTW'(1);
					state_q <= S_B_POP;
				end
				S_B_POP: begin
					state_q <= (head_q < tail_q) ? S_B_PAR : S_B_DONE;
				end
				S_B_PAR: begin
					parent_q <= queue_rd_q;
					f_q      <= queue_rd_q;
					head_q   <= head_q + CNTW'(1);
					state_q  <= S_B_PF;
				end
				S_B_PF: begin
					state_q <= S_B_PFC;
				end
				S_B_PFC: begin
					pfail_q  <= fail_rd_q;
					node_a_q <= parent_q;
					sym_a_q  <= '0;
					state_q  <= S_B_CRD;
				end
				S_B_CRD: begin
					state_q <= S_B_CCHK;
				end
				S_B_CCHK, S_B_GCHK: begin
					if (b_q_push) tail_q <= tail_q + CNTW'(1);
					if (b_next_c) begin
						node_a_q <= parent_q;
						sym_a_q  <= sym_a_q + SYM_W'(1);
						state_q  <= (sym_a_q == '1) ? S_B_POP : S_B_CRD;
					end else if (state_q == S_B_CCHK) begin
						child_q  <= child_rd_q;
						node_a_q <= pfail_q;
						f_q      <= pfail_q;
						state_q  <= S_B_GRD;
					end else begin
						node_a_q <= fail_rd_q;
						f_q      <= fail_rd_q;
						state_q  <= S_B_GRD;
					end
				end
				S_B_GRD: begin
					state_q <= S_B_GCHK;
				end
				S_B_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end

				// text scan
				S_T_RD: begin
					state_q <= S_T_CHK;
				end
				S_T_CHK: begin
					if ((node_a_q == '0) || (child_rd_q != '0)) begin
						search_node_q <= child_rd_q;
						f_q           <= child_rd_q;
						state_q       <= (child_rd_q == '0) ? S_T_END : S_T_QRD;
					end else begin
						node_a_q <= fail_rd_q;
						f_q      <= fail_rd_q;
						state_q  <= S_T_RD;
					end
				end
				S_T_QRD: begin
					state_q <= S_T_QD;
				end
				S_T_QD: begin
					if (!(t_hit && pend_v_q && !out_free)) begin
						if (t_hit) begin
							pend_v_q   <= 1'b1;
							pend_pat_q <= info_rd_q[ID_W-1:0];
							nres_q     <= nres_q + NCW'(1);
						end
						f_q     <= fail_rd_q;
						state_q <= (fail_rd_q == '0) ? S_T_END : S_T_QRD;
					end
				end
				S_T_END: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`MPSM_ASSERT_IMP(a_count_bound, 1'b1, node_count_q <= CNTW'(MAX_NODES), "node count past store size")
	`MPSM_ASSERT_IMP(a_depth_bound, 1'b1, ins_depth_q <= DW'(MAX_PATTERN_LEN), "insert depth past limit")
	`MPSM_ASSERT_IMP(a_push_free, push, out_free, "result pushed into occupied output register")
	`MPSM_ASSERT_NXT(a_text_start, accept && (mode == MODE_TEXT), state_q == S_T_RD, "text beat did not start walk")

endmodule

>>> dv/tb_multi_pattern_string_matcher.sv
// ----------------------------------------------------------------------------
// tb_multi_pattern_string_matcher
// drives pattern, build and text beats with random gaps and output stalls,
// predicts every result from its own trie model and checks it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_pattern_string_matcher;
	import mpsm_pkg::*;

	localparam int NODES    = MAX_NODES_DEF;
	localparam int PATTERNS = MAX_PATTERNS_DEF;
	localparam int MAX_LEN  = MAX_PATTERN_LEN_DEF;
	localparam int CHAIN_LEN = 10;
	localparam int IDLE_PCT = 36;
	localparam int WDOG_LIMIT = 1500000;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   pat;
		logic [POS_W-1:0]  pos;
		logic              fin;
	} result_t;

	typedef logic [SYM_W-1:0] sym_q_t[$];

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [MODE_W-1:0] mode;
	logic [SYM_W-1:0]  symbol;
	logic              last_of_pattern;
	logic [ID_W-1:0]   pattern_id;
	logic              start_of_text;
	logic              out_valid;
	logic              out_stall;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0]   match_pattern;
	logic [POS_W-1:0]  end_position;
	logic              last;

	multi_pattern_string_matcher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .symbol(symbol), .last_of_pattern(last_of_pattern),
		.pattern_id(pattern_id), .start_of_text(start_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .match_pattern(match_pattern),
		.end_position(end_position), .last(last)
	);

	// trie model state
	logic [ID_W-1:0]  trie_child [0:NODES*256-1];
	logic [ID_W-1:0]  fail_to [0:NODES-1];
	logic             is_terminal [0:NODES-1];
	logic [ID_W-1:0]  node_id [0:NODES-1];
	int               nodes_used;
	int               walk_node;
	int               walk_depth;
	logic             walk_failed;
	int               scan_node;
	logic [POS_W-1:0] scan_pos;

	result_t expected_results[$];
	result_t new_results[$];

	int  errors = 0;
	int  results_seen = 0;
	int  matches_seen = 0;
	int  beats_sent;
	int  quiet_cycles;
	logic calm;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [ID_W-1:0] child_at(int node, logic [SYM_W-1:0] s);
		return trie_child[(node << 8) | s];
	endfunction

	function automatic void add_result(logic [KIND_W-1:0] k, logic [ID_W-1:0] p,
			logic [POS_W-1:0] pos);
		result_t r;
		r.kind = k;
		r.pat  = p;
		r.pos  = pos;
		r.fin  = 1'b0;
		new_results = {new_results, r};
	endfunction

	// one pattern byte walks or grows the trie
	function automatic void insert_byte(logic [SYM_W-1:0] s, logic lp, logic [ID_W-1:0] id);
		int nxt;
		logic [ID_W-1:0] sid;
		sid = ID_W'(id % PATTERNS);
		if (!walk_failed) begin
			if (walk_depth >= MAX_LEN) begin
				walk_failed = 1'b1;
			end else begin
				nxt = child_at(walk_node, s);
				if (nxt == 0) begin
					if (nodes_used >= NODES) begin
						walk_failed = 1'b1;
					end else begin
						nxt = nodes_used;
						nodes_used++;
						trie_child[(walk_node << 8) | s] = ID_W'(nxt);
					end
				end
				if (!walk_failed) begin
					walk_node = nxt;
					walk_depth++;
				end
			end
		end
		if (lp) begin
			if (walk_failed) begin
				if (walk_depth >= MAX_LEN)
					add_result(KIND_LONG, sid, '0);
				else
					add_result(KIND_FULL, sid, '0);
			end else begin
				is_terminal[walk_node] = 1'b1;
				node_id[walk_node] = sid;
				add_result(KIND_STORED, sid, '0);
			end
			walk_node = 0;
			walk_depth = 0;
			walk_failed = 1'b0;
		end
	endfunction

	// breadth-first failure link fill
	function automatic void build_fail_links();
		int order [0:NODES-1];
		int head, tail, parent, child, link, f, g;
		head = 0;
		tail = 0;
		order[tail] = 0;
		tail++;
		fail_to[0] = '0;
		while (head < tail) begin
			parent = order[head];
			head++;
			for (int c = 0; c < 256; c++) begin
				child = child_at(parent, SYM_W'(c));
				if (child == 0)
					continue;
				link = 0;
				if (parent != 0) begin
					f = fail_to[parent];
					for (int st = 0; st < NODES; st++) begin
						g = child_at(f, SYM_W'(c));
						if (g != 0) begin
							link = g;
							break;
						end
						if (f == 0)
							break;
						f = fail_to[f];
					end
				end
				fail_to[child] = ID_W'(link);
				if (tail < NODES) begin
					order[tail] = child;
					tail++;
				end
			end
		end
		add_result(KIND_BUILT, '0, '0);
	endfunction

	// one text byte: goto/fail walk, then the output chain deepest first
	function automatic void scan_byte(logic [SYM_W-1:0] s, logic sot);
		int p, q, n;
		if (sot) begin
			scan_node = 0;
			scan_pos = '0;
		end
		p = scan_node;
		for (int st = 0; st < NODES; st++) begin
			if (p == 0 || child_at(p, s) != 0)
				break;
			p = fail_to[p];
		end
		p = child_at(p, s);
		scan_node = p;
		scan_pos++;
		q = p;
		n = 0;
		for (int st = 0; st < NODES && q != 0; st++) begin
			if (is_terminal[q] && n < RESULT_CAP) begin
				add_result(KIND_MATCH, node_id[q], scan_pos);
				n++;
			end
			q = fail_to[q];
		end
	endfunction

	function automatic void predict_beat(logic [MODE_W-1:0] m, logic [SYM_W-1:0] s,
			logic lp, logic [ID_W-1:0] id, logic sot);
		new_results.delete();
		case (m)
			MODE_PATTERN: insert_byte(s, lp, id);
			MODE_BUILD:   build_fail_links();
			MODE_TEXT:    scan_byte(s, sot);
			default: ;
		endcase
		if (new_results.size() > 0)
			new_results[new_results.size()-1].fin = 1'b1;
		expected_results = {expected_results, new_results};
	endfunction

	// send one beat, predict it when accepted, then maybe idle
	task automatic send_beat(input logic [MODE_W-1:0] m, input logic [SYM_W-1:0] s,
			input logic lp, input logic [ID_W-1:0] id, input logic sot);
		in_valid <= 1'b1;
		mode <= m;
		symbol <= s;
		last_of_pattern <= lp;
		pattern_id <= id;
		start_of_text <= sot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_beat(m, s, lp, id, sot);
		beats_sent++;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_pattern(input sym_q_t bytes, input logic [ID_W-1:0] id);
		foreach (bytes[i])
			send_beat(MODE_PATTERN, bytes[i], i == bytes.size() - 1,
				(i == bytes.size() - 1) ? id : ID_W'($urandom), 1'b0);
	endtask

	task automatic send_text(input sym_q_t bytes, input logic restart);
		foreach (bytes[i])
			send_beat(MODE_TEXT, bytes[i], 1'($urandom_range(0, 1)), ID_W'($urandom),
				restart && i == 0);
	endtask

	task automatic send_build();
		send_beat(MODE_BUILD, SYM_W'($urandom), 1'($urandom_range(0, 1)), ID_W'($urandom),
			1'($urandom_range(0, 1)));
	endtask

	// mismatch report
	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d (at %0t)", what, got, want, $realtime);
		errors++;
	endtask

	// result check
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (kind == KIND_MATCH)
				matches_seen++;
			if (expected_results.size() == 0) begin
				report("unexpected beat, kind", kind, -1);
			end else begin
				e = expected_results.pop_front();
				if (kind !== e.kind)
					report("kind", kind, e.kind);
				if (match_pattern !== e.pat)
					report("match_pattern", match_pattern, e.pat);
				if (end_position !== e.pos)
					report("end_position", end_position, e.pos);
				if (last !== e.fin)
					report("last", last, e.fin);
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
			$display("tb_multi_pattern_string_matcher: done, errors");
			$finish;
		end
	end

	function automatic sym_q_t str_bytes(input string txt);
		sym_q_t q;
		for (int i = 0; i < txt.len(); i++)
			q = {q, txt[i]};
		return q;
	endfunction

	// classic pattern set, extreme bytes and ids, repeats, ignored mode
	task automatic test_basic_patterns();
		sym_q_t ext;
		send_pattern(str_bytes("he"), 10'd0);
		send_pattern(str_bytes("she"), 10'd1023);
		send_pattern(str_bytes("his"), 10'h2AA);
		send_pattern(str_bytes("hers"), 10'h155);
		send_pattern(str_bytes("he"), 10'd512);
		ext = {8'h00, 8'hFF};
		send_pattern(ext, 10'd7);
		send_beat(MODE_UNUSED, 8'hFF, 1'b1, 10'h3FF, 1'b1);
		send_build();
		send_text(str_bytes("ushers"), 1'b1);
		send_text(ext, 1'b0);
		send_text(str_bytes("his"), 1'b1);
	endtask

	// a pattern one byte over the depth limit
	task automatic test_too_long();
		sym_q_t q;
		repeat (MAX_LEN + 1) q = {q, SYM_W'("q")};
		send_pattern(q, 10'd99);
		send_text(q, 1'b1);
	endtask

	// nested patterns give a long output chain on one byte
	task automatic test_deep_chain();
		sym_q_t q, t;
		calm = 1'b1;
		for (int k = 1; k <= CHAIN_LEN; k++) begin
			q = {q, SYM_W'("a")};
			send_pattern(q, ID_W'(100 + k));
		end
		send_build();
		repeat (CHAIN_LEN + 6) t = {t, SYM_W'("a")};
		send_text(t, 1'b1);
		calm = 1'b0;
	endtask

	// pattern added after the build is found only through goto edges
	task automatic test_unbuilt_links();
		send_pattern(str_bytes("xab"), 10'd300);
		send_text(str_bytes("axabxab"), 1'b1);
		send_build();
		send_text(str_bytes("axabxab"), 1'b1);
	endtask

	function automatic logic [SYM_W-1:0] rand_sym();
		if ($urandom_range(0, 9) == 0)
			return SYM_W'($urandom);
		return SYM_W'($urandom_range(8'h61, 8'h64));
	endfunction

	// rounds of random patterns, a build (skipped in one round), random text, some noise
	task automatic test_random_rounds();
		sym_q_t q, t;
		for (int r = 0; r < 5; r++) begin
			repeat ($urandom_range(3, 6)) begin
				q.delete();
				repeat ($urandom_range(1, 5)) q = {q, rand_sym()};
				send_pattern(q, ID_W'($urandom));
			end
			if (r != 2)
				send_build();
			t.delete();
			repeat (40) t = {t, rand_sym()};
			foreach (t[i]) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(MODE_UNUSED, SYM_W'($urandom), 1'($urandom_range(0, 1)),
						ID_W'($urandom), 1'($urandom_range(0, 1)));
				send_beat(MODE_TEXT, t[i], 1'($urandom_range(0, 1)), ID_W'($urandom),
					$urandom_range(0, 19) == 0);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < NODES * 256; i++)
			trie_child[i] = '0;
		for (int i = 0; i < NODES; i++) begin
			fail_to[i] = '0;
			is_terminal[i] = 1'b0;
			node_id[i] = '0;
		end
		nodes_used = 1;
		walk_node = 0;
		walk_depth = 0;
		walk_failed = 1'b0;
		scan_node = 0;
		scan_pos = '0;
		beats_sent = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PATTERN;
		symbol = '0;
		last_of_pattern = 1'b0;
		pattern_id = '0;
		start_of_text = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_patterns();
		test_too_long();
		test_deep_chain();
		test_unbuilt_links();
		test_random_rounds();

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d beats in, %0d results out (%0d matches), trie of %0d nodes",
			beats_sent, results_seen, matches_seen, nodes_used);
		$display("patterns, builds, over-long patterns, nested match chains, stale links");
		if (errors == 0)
			$display("tb_multi_pattern_string_matcher: done, clean");
		else
			$display("tb_multi_pattern_string_matcher: done, errors");
		$finish;
	end

endmodule
